// ===== hdl/stsb_pkg.sv =====
// Shared types and constants for the sorted-table binary search block.
// Holds the request/response payload structs and the table port struct.
// No dependencies.
package stsb_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int WORD_BITS   = 32;
	localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
	// Window bounds run from 0 up to TABLE_DEPTH inclusive
	localparam int BOUND_BITS  = ADDR_BITS + 1;
	// Start plus length, one bit more than the widest term
	localparam int SUM_BITS    = BOUND_BITS + 1;

	// Fixed field widths of the request and response
	localparam int ENTRY_BITS  = 10;
	localparam int KEY_BITS    = 32;
	localparam int START_BITS  = 10;
	localparam int SPAN_BITS   = 11;
	localparam int POS_BITS    = 12;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic                         action;
		logic        [ENTRY_BITS-1:0] entry_addr;
		logic signed [KEY_BITS-1:0]   word;
		logic        [START_BITS-1:0] start_index;
		logic        [SPAN_BITS-1:0]  span_length;
	} req_t;

	typedef struct packed {
		logic                       found;
		logic signed [POS_BITS-1:0] position;
		logic                       range_error;
	} rsp_t;

	typedef struct packed {
		logic                        wr_en;
		logic        [ADDR_BITS-1:0] wr_addr;
		logic signed [WORD_BITS-1:0] wr_data;
		logic                        rd_en;
		logic        [ADDR_BITS-1:0] rd_addr;
	} tbl_req_t;

endpackage

// ===== hdl/stsb_table.sv =====
// Table storage: one write port and one read port with registered read data.
// Depends on stsb_pkg for the depth, word width and port struct.
module stsb_table (
	input  logic                                  clk,
	input  stsb_pkg::tbl_req_t                    port,
	output logic signed [stsb_pkg::WORD_BITS-1:0] rd_data
);

	logic signed [stsb_pkg::WORD_BITS-1:0] mem [stsb_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (port.wr_en) begin
			mem[port.wr_addr] <= port.wr_data;
		end
		// hold read data until the next probe
		if (port.rd_en) begin
			rd_data <= mem[port.rd_addr];
		end
	end

endmodule

// ===== hdl/sorted_table_binary_search.sv =====
// Top level of the sorted-table binary search block.
// Depends on stsb_pkg and stsb_table.
//
// Usage:
//  - One request channel (req_valid, req_stall, req) and one response channel
//    (rsp_valid, rsp_stall, rsp). A transfer happens on a rising edge where
//    valid is high and stall is low.
//  - A write request (action = write) stores word at entry_addr and produces
//    no response.
//  - A search request looks for word in the window start_index ..
//    start_index + span_length - 1, which must be sorted ascending (signed).
//    The response carries found, the match index or the complement of the
//    insertion point, and range_error when the window runs past the table.
//  - Search steps: the request is taken, the table is probed, and the result
//    moves to the output register. A probe is one read of the table
//    memory, so a window of N entries takes up to floor(log2 N) + 1
//    probes: at most 11 probes for a full 1024 entry window. Range errors
//    and empty windows skip the probes and go straight to the finish state.
//  - One request is worked on at a time; req_stall is high from the search
//    request until its result enters the output register.
//  - When the receiver stalls, the response register holds; a finished
//    result waits in the finish state until that register frees up.
//  - Reset (arst_n low) returns to idle and drops any pending response. The
//    table contents are not cleared; search only entries already written.
module sorted_table_binary_search (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  stsb_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output stsb_pkg::rsp_t rsp
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_PROBE  = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;

	// search window as [lo, hi) so an empty window needs no negative bound
	logic        [stsb_pkg::BOUND_BITS-1:0] lo_q;
	logic        [stsb_pkg::BOUND_BITS-1:0] hi_q;
	logic        [stsb_pkg::ADDR_BITS-1:0]  mid_q;
	logic signed [stsb_pkg::WORD_BITS-1:0]  key_q;
	stsb_pkg::rsp_t                         res_q;
	stsb_pkg::rsp_t                         rsp_q;
	logic                                   rsp_valid_q;

	stsb_pkg::tbl_req_t                     tbl_port;
	logic signed [stsb_pkg::WORD_BITS-1:0]  rd_data;

	logic                                   req_acc;
	logic                                   is_search;
	logic                                   rsp_free;

	// request decode
	logic        [stsb_pkg::SUM_BITS-1:0]   win_end;
	logic                                   win_err;
	logic                                   span_zero;
	logic        [stsb_pkg::BOUND_BITS-1:0] span_dec;
	logic        [stsb_pkg::BOUND_BITS-1:0] mid0;
	logic signed [stsb_pkg::WORD_BITS-1:0]  key_in;

	// probe step
	logic                                   e_eq;
	logic                                   e_lt;
	logic        [stsb_pkg::BOUND_BITS-1:0] mid_ext;
	logic        [stsb_pkg::BOUND_BITS-1:0] lo_a;
	logic        [stsb_pkg::BOUND_BITS-1:0] mid_a;
	logic        [stsb_pkg::BOUND_BITS-1:0] mid_b;
	logic                                   cont_a;
	logic                                   cont_b;
	logic        [stsb_pkg::BOUND_BITS-1:0] lo_n;
	logic        [stsb_pkg::BOUND_BITS-1:0] hi_n;
	logic        [stsb_pkg::BOUND_BITS-1:0] mid_n;
	logic                                   cont;

	stsb_table u_table (
		.clk     (clk),
		.port    (tbl_port),
		.rd_data (rd_data)
	);

	// Handshake: take a request only while idle
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign is_search = (req.action == stsb_pkg::ACT_SEARCH);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// Window decode: end bound, range check and first midpoint
	assign win_end   = stsb_pkg::SUM_BITS'(req.start_index)
	                 + stsb_pkg::SUM_BITS'(req.span_length);
	assign win_err   = win_end > stsb_pkg::SUM_BITS'(stsb_pkg::TABLE_DEPTH);
	assign span_zero = (req.span_length == '0);
	assign span_dec  = stsb_pkg::BOUND_BITS'(req.span_length) - 1'b1;
	assign mid0      = stsb_pkg::BOUND_BITS'(req.start_index) + (span_dec >> 1);
	assign key_in    = $signed(req.word[stsb_pkg::WORD_BITS-1:0]);

	// Probe: compare the entry read at mid_q with the key. Both possible
	// next windows and midpoints come from registered bounds, so the compare
	// only steers a final select.
	assign e_eq    = (rd_data == key_q);
	assign e_lt    = (rd_data < key_q);
	assign mid_ext = stsb_pkg::BOUND_BITS'(mid_q);

	// entry below key: advance lo past mid
	assign lo_a    = mid_ext + 1'b1;
	assign cont_a  = lo_a < hi_q;
	assign mid_a   = lo_a + ((hi_q - lo_a - 1'b1) >> 1);
	// entry above key: pull hi down to mid
	assign cont_b  = lo_q < mid_ext;
	assign mid_b   = lo_q + ((mid_ext - lo_q - 1'b1) >> 1);

	assign lo_n    = e_lt ? lo_a   : lo_q;
	assign hi_n    = e_lt ? hi_q   : mid_ext;
	assign cont    = e_lt ? cont_a : cont_b;
	assign mid_n   = e_lt ? mid_a  : mid_b;

	// Table port: writes from idle, reads for the first and following probes
	always_comb begin
		tbl_port.wr_en   = req_acc && !is_search
		                 && (stsb_pkg::SUM_BITS'(req.entry_addr)
		                     < stsb_pkg::SUM_BITS'(stsb_pkg::TABLE_DEPTH));
		tbl_port.wr_addr = req.entry_addr[stsb_pkg::ADDR_BITS-1:0];
		tbl_port.wr_data = key_in;
		tbl_port.rd_en   = 1'b0;
		tbl_port.rd_addr = mid0[stsb_pkg::ADDR_BITS-1:0];
		unique case (state_q)
			ST_IDLE: begin
				tbl_port.rd_en   = req_acc && is_search && !win_err && !span_zero;
				tbl_port.rd_addr = mid0[stsb_pkg::ADDR_BITS-1:0];
			end
			ST_PROBE: begin
				tbl_port.rd_en   = !e_eq && cont;
				tbl_port.rd_addr = mid_n[stsb_pkg::ADDR_BITS-1:0];
			end
			ST_FINISH: begin
				tbl_port.rd_en   = 1'b0;
			end
			default: begin
				tbl_port.rd_en   = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && is_search) begin
						if (win_err || span_zero) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (e_eq || !cont) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// load on finish, drop once the receiver takes it
			if (state_q == ST_FINISH && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload: window bounds, key and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc && is_search) begin
					key_q <= key_in;
					lo_q  <= stsb_pkg::BOUND_BITS'(req.start_index);
					hi_q  <= win_end[stsb_pkg::BOUND_BITS-1:0];
					mid_q <= mid0[stsb_pkg::ADDR_BITS-1:0];
					if (win_err) begin
						res_q.found       <= 1'b0;
						res_q.position    <= '0;
						res_q.range_error <= 1'b1;
					end else begin
						// empty window: insertion point is the start
						res_q.found       <= 1'b0;
						res_q.position    <= ~stsb_pkg::POS_BITS'(req.start_index);
						res_q.range_error <= 1'b0;
					end
				end
			end
			ST_PROBE: begin
				if (e_eq) begin
					res_q.found       <= 1'b1;
					res_q.position    <= stsb_pkg::POS_BITS'(mid_q);
					res_q.range_error <= 1'b0;
				end else if (cont) begin
					lo_q  <= lo_n;
					hi_q  <= hi_n;
					mid_q <= mid_n[stsb_pkg::ADDR_BITS-1:0];
				end else begin
					res_q.found       <= 1'b0;
					res_q.position    <= ~stsb_pkg::POS_BITS'(lo_n);
					res_q.range_error <= 1'b0;
				end
			end
			ST_FINISH: begin
				if (rsp_free) begin
					rsp_q <= res_q;
				end
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A response only appears right after the finish state
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_FINISH))
		else $error("response raised outside the finish state");

	// A probe always works on a non-empty window
	a_probe_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (lo_q < hi_q) && (mid_ext >= lo_q) && (mid_ext < hi_q))
		else $error("probe midpoint outside its window");

	// A range error carries no match and a zero position
	a_range_err_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.range_error) |-> (!rsp.found && rsp.position == '0))
		else $error("range error response with match data");

	// A match reports a non-negative index
	a_found_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |-> !rsp.position[stsb_pkg::POS_BITS-1])
		else $error("match reported with a negative position");

endmodule

// ===== tb/stsb_search_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for the sorted-table binary search testbench: shadow table,
// search predictor and in-order response checker. Depends on stsb_pkg.
package tb_stsb_scoreboard_pkg;
	import stsb_pkg::*;

	class search_scoreboard;
		logic signed [WORD_BITS-1:0] shadow_words [TABLE_DEPTH];
		rsp_t                        pending_answers [$];
		int unsigned                 errors;
		int unsigned                 write_count;
		int unsigned                 search_count;
		int unsigned                 hit_count;
		int unsigned                 range_err_count;
		int unsigned                 empty_count;

		// Walk the window the way the block does: midpoint low + half the span.
		function rsp_t search_outcome(req_t r);
			rsp_t                       answer;
			logic signed [KEY_BITS-1:0] probe_key;
			int                         lo;
			int                         hi;
			int                         mid;
			int                         pos;
			bit                         hit;
			answer = '0;
			hit    = 1'b0;
			if (int'(r.start_index) + int'(r.span_length) > TABLE_DEPTH) begin
				answer.range_error = 1'b1;
				return answer;
			end
			probe_key = r.word;
			lo        = int'(r.start_index);
			hi        = lo + int'(r.span_length) - 1;
			pos       = 0;
			while (!hit && lo <= hi) begin
				mid = lo + ((hi - lo) >> 1);
				if (shadow_words[mid] == probe_key) begin
					hit = 1'b1;
					pos = mid;
				end else if (shadow_words[mid] < probe_key) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
			if (!hit)
				pos = -lo - 1;
			answer.found    = hit;
			answer.position = pos[POS_BITS-1:0];
			return answer;
		endfunction

		function void note_request(req_t r);
			rsp_t answer;
			if (r.action == ACT_WRITE) begin
				shadow_words[r.entry_addr] = r.word;
				write_count++;
				return;
			end
			answer = search_outcome(r);
			search_count++;
			if (answer.range_error)
				range_err_count++;
			else if (r.span_length == 0)
				empty_count++;
			else if (answer.found)
				hit_count++;
			pending_answers.push_back(answer);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_answers.size() == 0) begin
				errors++;
				$display("%0t: response with none expected: found=%0b position=%0d range_error=%0b",
					$time, got.found, $signed(got.position), got.range_error);
				return;
			end
			want = pending_answers.pop_front();
			if (got.found !== want.found) begin
				errors++;
				$display("%0t: found mismatch: expected %0b, got %0b", $time, want.found, got.found);
			end
			if (got.position !== want.position) begin
				errors++;
				$display("%0t: position mismatch: expected %0d, got %0d",
					$time, $signed(want.position), $signed(got.position));
			end
			if (got.range_error !== want.range_error) begin
				errors++;
				$display("%0t: range_error mismatch: expected %0b, got %0b",
					$time, want.range_error, got.range_error);
			end
		endfunction

		function int unsigned outstanding();
			return pending_answers.size();
		endfunction
	endclass

endpackage

// ===== tb/tb_sorted_table_binary_search.sv =====
`timescale 1ns / 100ps
// Top-level testbench for sorted_table_binary_search: drives write and search
// requests with random idling and response stalls, checks every answer.
// Depends on stsb_pkg and tb_stsb_scoreboard_pkg.
module tb_sorted_table_binary_search;
	import stsb_pkg::*;
	import tb_stsb_scoreboard_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int ITEM_TARGET  = 1550;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_PCT     = 26;
	localparam int SPAN_MAX     = (1 << SPAN_BITS) - 1;
	localparam logic signed [KEY_BITS-1:0] WORD_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
	localparam logic signed [KEY_BITS-1:0] WORD_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Idling switches, cleared for the long stretch without gaps
	bit          sender_idles    = 1'b1;
	bit          receiver_stalls = 1'b1;
	int unsigned sent_count      = 0;
	int unsigned cycle_count     = 0;

	search_scoreboard sb;

	sorted_table_binary_search u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the response channel at random while stalls are enabled.
	always @(posedge clk) begin
		rsp_stall <= receiver_stalls && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Take each response on the edge where it is handed over; values read here
	// are the ones from before the edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	// Count cycles and end the run if it never finishes on its own.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("DONE: errors detected");
		$finish;
	end

	// Present one request and hold it until the block takes it. Idle gaps go
	// in front, so valid stays high between back-to-back requests.
	task automatic push_request(input req_t r);
		if (sender_idles) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req       <= r;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall);
		sb.note_request(r);
		sent_count++;
	endtask

	// Fields a write does not use still get random values.
	task automatic write_entry(input int addr, input logic signed [KEY_BITS-1:0] value);
		req_t r;
		r.action      = ACT_WRITE;
		r.entry_addr  = addr[ENTRY_BITS-1:0];
		r.word        = value;
		r.start_index = START_BITS'($urandom_range(0, TABLE_DEPTH - 1));
		r.span_length = SPAN_BITS'($urandom_range(0, SPAN_MAX));
		push_request(r);
	endtask

	task automatic search_window(input int start, input int len,
		input logic signed [KEY_BITS-1:0] value);
		req_t r;
		r.action      = ACT_SEARCH;
		r.entry_addr  = ENTRY_BITS'($urandom_range(0, TABLE_DEPTH - 1));
		r.word        = value;
		r.start_index = start[START_BITS-1:0];
		r.span_length = len[SPAN_BITS-1:0];
		push_request(r);
	endtask

	// Write an ascending run with duplicates, small steps and jumps up to
	// max_jump; saturate at the top of the signed range.
	task automatic fill_sorted_block(input int base, input int block_len, input int max_jump);
		longint walk;
		if ($urandom_range(0, 3) == 0)
			walk = longint'(WORD_MIN) + $urandom_range(0, 3);
		else
			walk = longint'($signed($urandom));
		for (int i = 0; i < block_len; i++) begin
			write_entry(base + i, walk[KEY_BITS-1:0]);
			case ($urandom_range(0, 9))
				0, 1: ;
				2, 3, 4, 5, 6: walk += $urandom_range(1, 8);
				default: walk += $urandom_range(9, max_jump);
			endcase
			if (walk > longint'(WORD_MAX))
				walk = longint'(WORD_MAX);
		end
	endtask

	// Pick a key for a window: mostly a stored value or its neighbor, else an
	// extreme or noise. An empty window has no stored value to lean on.
	function automatic logic signed [KEY_BITS-1:0] pick_key(input int start, input int len);
		logic signed [KEY_BITS-1:0] stored;
		stored = (len > 0) ? sb.shadow_words[start + $urandom_range(0, len - 1)] : WORD_MAX;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return stored;
			4: return stored + 1;
			5: return stored - 1;
			6: return WORD_MIN;
			7: return WORD_MAX;
			default: return $signed($urandom);
		endcase
	endfunction

	// Odd searches: window past the end, empty window, or any window at all.
	// Use only once every entry has been written.
	task automatic search_noise();
		int start;
		int len;
		start = $urandom_range(0, TABLE_DEPTH - 1);
		case ($urandom_range(0, 2))
			0: len = $urandom_range(TABLE_DEPTH - start + 1, SPAN_MAX);
			1: len = 0;
			default: len = $urandom_range(0, TABLE_DEPTH - start);
		endcase
		search_window(start, len, pick_key(start, (start + len > TABLE_DEPTH) ? 0 : len));
	endtask

	// Drop valid and hold off until every outstanding search has answered.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.outstanding() != 0);
	endtask

	initial begin
		int block_len;
		int base;
		int start;
		int len;
		int round_no;
		sb = new;

		// Hold reset low, then release it on an edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a short sorted run at the bottom with a triple
		// duplicate and both extremes, plus the top entry. Search only
		// written entries here.
		write_entry(0, WORD_MIN);
		write_entry(1, -5);
		write_entry(2, 0);
		write_entry(3, 7);
		write_entry(4, 7);
		write_entry(5, 7);
		write_entry(6, 100);
		write_entry(7, WORD_MAX);
		write_entry(TABLE_DEPTH - 1, WORD_MAX);
		search_window(0, 8, WORD_MIN);                        // first entry
		search_window(0, 8, WORD_MAX);                        // last entry, longest path
		search_window(0, 8, 7);                               // equal entries
		search_window(0, 8, 8);                               // miss between entries
		search_window(0, 8, -6);
		search_window(0, 7, WORD_MAX);                        // miss past the window
		search_window(1, 7, WORD_MIN);                        // miss before the window
		search_window(TABLE_DEPTH - 1, 1, WORD_MAX);          // hit at the top index
		search_window(TABLE_DEPTH - 1, 1, WORD_MIN);
		search_window(TABLE_DEPTH - 1, 0, 0);                 // empty window at the top
		search_window(0, 0, WORD_MAX);                        // empty window at zero
		search_window(TABLE_DEPTH - 1, 2, 0);                 // one past the end
		search_window(1, TABLE_DEPTH, 0);                     // full length, shifted
		search_window(TABLE_DEPTH - 1, SPAN_MAX, WORD_MIN);   // widest span field
		wait_for_drain();

		// Long stretch with no idling on either side: fill the whole table in
		// order, then search it, often over the full depth.
		sender_idles    = 1'b0;
		receiver_stalls = 1'b0;
		fill_sorted_block(0, TABLE_DEPTH, 1 << 22);
		search_window(0, TABLE_DEPTH, WORD_MAX);
		search_window(0, TABLE_DEPTH, WORD_MIN);
		repeat (40) begin
			if ($urandom_range(0, 2) == 0) begin
				start = 0;
				len   = TABLE_DEPTH;
			end else begin
				start = $urandom_range(0, TABLE_DEPTH - 1);
				len   = $urandom_range(1, TABLE_DEPTH - start);
			end
			search_window(start, len, pick_key(start, len));
		end
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;

		// Random rounds: rewrite a sorted block, mostly small, then search
		// inside it, with some noise and the odd write that breaks the order.
		round_no = 0;
		while (sent_count < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0: block_len = $urandom_range(101, 300);
				1, 2, 3: block_len = $urandom_range(25, 100);
				default: block_len = $urandom_range(2, 24);
			endcase
			base = $urandom_range(0, TABLE_DEPTH - block_len);
			fill_sorted_block(base, block_len, (1 << 28) / block_len + 9);
			repeat ($urandom_range(6, 20)) begin
				case ($urandom_range(0, 19))
					0, 1: search_noise();
					2: write_entry(base + $urandom_range(0, block_len - 1), $signed($urandom));
					3: search_window(base, block_len, pick_key(base, block_len));
					default: begin
						start = base + $urandom_range(0, block_len - 1);
						len   = $urandom_range(1, base + block_len - start);
						search_window(start, len, pick_key(start, len));
					end
				endcase
			end
			round_no++;
			if (round_no % 5 == 0)
				wait_for_drain();
		end

		// Let the last answers come back, then watch for stray responses.
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests: %0d writes, %0d searches", sent_count,
			sb.write_count, sb.search_count);
		$display("Searches: %0d hits, %0d empty windows, %0d out of range",
			sb.hit_count, sb.empty_count, sb.range_err_count);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sorted_table_binary_search.f =====
hdl/stsb_pkg.sv
hdl/stsb_table.sv
hdl/sorted_table_binary_search.sv
tb/stsb_search_scoreboard.sv
tb/tb_sorted_table_binary_search.sv
